@@ rtl/skde_pkg.sv @@
package skde_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 16;
  localparam int RECIP_W    = 18;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 18;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_TOP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE_RECIP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SLOPE = 3'd5;

  localparam logic [15:0] RST_PEAK_DECAY = 16'd65521;
  localparam logic [15:0] RST_ATTACK     = 16'd65171;
  localparam logic [15:0] RST_RELEASE    = 16'd65522;
  localparam logic [15:0] RST_KNEE_TOP   = 16'hDB00;
  localparam logic [17:0] RST_KNEE_RECIP = 18'd85;
  localparam logic [15:0] RST_GAIN_SLOPE = 16'hF99A;

  localparam logic [16:0] ONE_Q16        = 17'h10000;
  localparam logic [17:0] DB_PER_OCT_Q12 = 18'd24660;
  localparam logic [17:0] LOG2_TEN_Q14   = 18'd54426;

  // 2^(-i/16) in Q1.16
  function automatic logic [16:0] exp2_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/soft_knee_downward_expander_top.sv @@
// timing: the run from input word to output word grows with the leading zeros of the smoothed
//   level and is shortest when the level is zero; one shared 32x18 multiplier does every product,
//   and the 12-step log mantissa squaring (states S_LG0, S_LG1 per step) dominates
// throughput: no new word until the last is out; a finished word waits in the output register
// reset: synchronous active-low rst_n clears both followers and loads the default coefficients
module soft_knee_downward_expander_top #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [skde_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [skde_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int W    = SAMPLE_BITS;
  localparam int LZ_W = $clog2(SAMPLE_BITS);
  localparam int PW   = skde_pkg::PROD_W;
  localparam logic [15:0] DB_FLOOR_MAG = 16'(SAMPLE_BITS * 1542);

  typedef enum logic [4:0] {
    S_IDLE, S_PK0, S_PK1, S_PK2, S_LV0, S_LV1, S_LV2, S_LV3, S_NM,
    S_LG0, S_LG1, S_DB0, S_DB1, S_KN0, S_KN1, S_KN2, S_KN3, S_KN4,
    S_GS0, S_GS1, S_GS2, S_GS3, S_EX0, S_EX1, S_OUT0, S_OUT1
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [W-1:0] out_r, out_nxt;
  logic [W-1:0] samp_r, samp_nxt, mag_r, mag_nxt;
  logic [W-1:0] peak_r, peak_nxt, level_r, level_nxt, x_r, x_nxt, norm_r, norm_nxt;
  logic [15:0] coef_r, coef_nxt;
  logic [PW-1:0] acc_r, acc_nxt, prod_r, prod_nxt;
  logic [LZ_W-1:0] lz_r, lz_nxt;
  logic [15:0] m_r, m_nxt;
  logic [11:0] frac_r, frac_nxt;
  logic [3:0] it_r, it_nxt;
  logic [15:0] dbm_r, dbm_nxt, d_r, d_nxt, e_r, e_nxt;
  logic [16:0] k_r, k_nxt, g_r, g_nxt;
  logic [31:0] t_r, t_nxt;
  logic [25:0] u_r, u_nxt;
  logic [15:0] peak_coef_r, peak_coef_nxt, attack_r, attack_nxt, release_r, release_nxt;
  logic [15:0] knee_top_r, knee_top_nxt, gain_slope_r, gain_slope_nxt;
  logic [17:0] knee_recip_r, knee_recip_nxt;

  logic [skde_pkg::MUL_A_W-1:0] mul_a;
  logic [skde_pkg::MUL_B_W-1:0] mul_b;
  logic [PW:0] fsum;
  logic [PW:0] rnd16;
  logic [16:0] sq;
  logic [16:0] tab_lo, tab_hi, g_int;
  logic [W-1:0] y;
  logic [LZ_W+11:0] neg;
  logic signed [17:0] dsum;
  logic [15:0] gs_mag;
  logic [9:0] oct_n;

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;
  assign cfg_ready      = 1'b1;

  assign prod_nxt = PW'(mul_a) * PW'(mul_b);
  assign fsum     = {1'b0, acc_r} + {1'b0, prod_r} + (PW+1)'(32768);
  assign rnd16    = {1'b0, prod_r} + (PW+1)'(32768);
  assign sq       = prod_r[31:15];
  assign neg      = (lz_r == '0) ? '0 : ({lz_r, 12'b0} - (LZ_W+12)'(frac_r));
  assign dsum     = $signed({{2{knee_top_r[15]}}, knee_top_r}) + $signed({2'b00, dbm_r});
  assign gs_mag   = gain_slope_r[15] ? (16'd0 - gain_slope_r) : 16'd0;
  assign tab_lo   = skde_pkg::exp2_tab({1'b0, u_r[15:12]});
  assign tab_hi   = skde_pkg::exp2_tab({1'b0, u_r[15:12]} + 5'd1);
  assign g_int    = tab_lo - 17'((prod_r + PW'(2048)) >> 12);
  assign oct_n    = u_r[25:16];
  assign y        = rnd16[W+15:16];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_PK0: begin
        mul_a = 32'(peak_r); mul_b = 18'(peak_coef_r);
      end
      S_PK1: begin
        mul_a = 32'(mag_r); mul_b = 18'(skde_pkg::ONE_Q16 - 17'(peak_coef_r));
      end
      S_LV1: begin
        mul_a = 32'(level_r); mul_b = 18'(coef_r);
      end
      S_LV2: begin
        mul_a = 32'(x_r); mul_b = 18'(skde_pkg::ONE_Q16 - 17'(coef_r));
      end
      S_LG0: begin
        mul_a = 32'(m_r); mul_b = 18'(m_r);
      end
      S_DB0: begin
        mul_a = 32'(neg); mul_b = skde_pkg::DB_PER_OCT_Q12;
      end
      S_KN1: begin
        mul_a = 32'(d_r); mul_b = knee_recip_r;
      end
      S_KN3: begin
        mul_a = 32'(d_r); mul_b = 18'(k_r);
      end
      S_GS0: begin
        mul_a = 32'(e_r); mul_b = 18'(gs_mag);
      end
      S_GS2: begin
        mul_a = t_r; mul_b = skde_pkg::LOG2_TEN_Q14;
      end
      S_EX0: begin
        mul_a = 32'(tab_lo - tab_hi); mul_b = 18'(u_r[11:0]);
      end
      // product held while the finished word waits for the output register
      S_OUT0, S_OUT1: begin
        mul_a = 32'(mag_r); mul_b = 18'(g_r);
      end
      default: begin
        mul_a = '0; mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    samp_nxt = samp_r; mag_nxt = mag_r; peak_nxt = peak_r; level_nxt = level_r;
    x_nxt = x_r; norm_nxt = norm_r; coef_nxt = coef_r; acc_nxt = acc_r;
    lz_nxt = lz_r; m_nxt = m_r; frac_nxt = frac_r; it_nxt = it_r;
    dbm_nxt = dbm_r; d_nxt = d_r; e_nxt = e_r; k_nxt = k_r; g_nxt = g_r;
    t_nxt = t_r; u_nxt = u_r;
    peak_coef_nxt = peak_coef_r; attack_nxt = attack_r; release_nxt = release_r;
    knee_top_nxt = knee_top_r; knee_recip_nxt = knee_recip_r; gain_slope_nxt = gain_slope_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        skde_pkg::REG_PEAK_DECAY: peak_coef_nxt = cfg_data[15:0];
        skde_pkg::REG_ATTACK:     attack_nxt = cfg_data[15:0];
        skde_pkg::REG_RELEASE:    release_nxt = cfg_data[15:0];
        skde_pkg::REG_KNEE_TOP:   knee_top_nxt = cfg_data[15:0];
        skde_pkg::REG_KNEE_RECIP: knee_recip_nxt = cfg_data;
        skde_pkg::REG_GAIN_SLOPE: gain_slope_nxt = cfg_data[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          samp_nxt = in_sample_in;
          mag_nxt = in_sample_in[W-1] ? (W'(0) - in_sample_in) : in_sample_in;
          state_nxt = S_PK0;
        end
      end
      S_PK0: state_nxt = S_PK1;
      S_PK1: begin
        acc_nxt = prod_r;
        state_nxt = S_PK2;
      end
      S_PK2: begin
        peak_nxt = fsum[W+15:16];
        state_nxt = S_LV0;
      end
      S_LV0: begin
        // positive sample above the peak becomes the level follower's target in place of the peak
        if ($signed({samp_r[W-1], samp_r}) > $signed({1'b0, peak_r})) begin
          x_nxt = samp_r;
        end else begin
          x_nxt = peak_r;
        end
        coef_nxt = (level_r < x_nxt) ? attack_r : release_r;
        state_nxt = S_LV1;
      end
      S_LV1: state_nxt = S_LV2;
      S_LV2: begin
        acc_nxt = prod_r;
        state_nxt = S_LV3;
      end
      S_LV3: begin
        level_nxt = fsum[W+15:16];
        norm_nxt = fsum[W+15:16];
        lz_nxt = '0;
        state_nxt = S_NM;
      end
      S_NM: begin
        if (norm_r == '0) begin
          dbm_nxt = DB_FLOOR_MAG;
          state_nxt = S_KN0;
        end else if (norm_r[W-1]) begin
          m_nxt = norm_r[W-1 -: 16];
          frac_nxt = '0;
          it_nxt = '0;
          state_nxt = S_LG0;
        end else begin
          norm_nxt = norm_r << 1;
          lz_nxt = lz_r + 1'b1;
        end
      end
      S_LG0: state_nxt = S_LG1;
      S_LG1: begin
        frac_nxt = {frac_r[10:0], sq[16]};
        m_nxt = sq[16] ? sq[16:1] : sq[15:0];
        it_nxt = it_r + 4'd1;
        state_nxt = (it_r == 4'd11) ? S_DB0 : S_LG0;
      end
      S_DB0: state_nxt = S_DB1;
      S_DB1: begin
        dbm_nxt = rnd16[31:16];
        state_nxt = S_KN0;
      end
      S_KN0: begin
        d_nxt = dsum[17] ? 16'd0 : dsum[15:0];
        state_nxt = S_KN1;
      end
      S_KN1: state_nxt = S_KN2;
      S_KN2: begin
        k_nxt = (prod_r > PW'(skde_pkg::ONE_Q16)) ? skde_pkg::ONE_Q16 : prod_r[16:0];
        state_nxt = S_KN3;
      end
      S_KN3: state_nxt = S_KN4;
      S_KN4: begin
        e_nxt = rnd16[31:16];
        state_nxt = S_GS0;
      end
      S_GS0: state_nxt = S_GS1;
      S_GS1: begin
        t_nxt = prod_r[31:0];
        state_nxt = S_GS2;
      end
      S_GS2: state_nxt = S_GS3;
      S_GS3: begin
        u_nxt = 26'((prod_r + PW'(1 << 20)) >> 21);
        state_nxt = S_EX0;
      end
      S_EX0: state_nxt = S_EX1;
      S_EX1: begin
        // 17 octaves or more leaves nothing of the gain
        g_nxt = (oct_n >= 10'd17) ? 17'd0 : (g_int >> oct_n[4:0]);
        state_nxt = S_OUT0;
      end
      S_OUT0: state_nxt = S_OUT1;
      S_OUT1: begin
        if (!out_valid_r || out_ready) begin
          out_nxt = samp_r[W-1] ? (W'(0) - y) : y;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      peak_r <= '0;
      level_r <= '0;
      peak_coef_r <= skde_pkg::RST_PEAK_DECAY;
      attack_r <= skde_pkg::RST_ATTACK;
      release_r <= skde_pkg::RST_RELEASE;
      knee_top_r <= skde_pkg::RST_KNEE_TOP;
      knee_recip_r <= skde_pkg::RST_KNEE_RECIP;
      gain_slope_r <= skde_pkg::RST_GAIN_SLOPE;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      peak_r <= peak_nxt;
      level_r <= level_nxt;
      peak_coef_r <= peak_coef_nxt;
      attack_r <= attack_nxt;
      release_r <= release_nxt;
      knee_top_r <= knee_top_nxt;
      knee_recip_r <= knee_recip_nxt;
      gain_slope_r <= gain_slope_nxt;
    end
    out_r <= out_nxt;
    samp_r <= samp_nxt;
    mag_r <= mag_nxt;
    x_r <= x_nxt;
    norm_r <= norm_nxt;
    coef_r <= coef_nxt;
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    lz_r <= lz_nxt;
    m_r <= m_nxt;
    frac_r <= frac_nxt;
    it_r <= it_nxt;
    dbm_r <= dbm_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
    k_r <= k_nxt;
    g_r <= g_nxt;
    t_r <= t_nxt;
    u_r <= u_nxt;
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_PK0)
    else $error("accepted word did not start the sequence");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= (W'(1) << (W-1)) && peak_r <= (W'(1) << (W-1)))
    else $error("follower exceeded full scale");

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT0 |-> g_r <= skde_pkg::ONE_Q16)
    else $error("gain above unity");

  a_knee_sat: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_KN3 |-> k_r <= skde_pkg::ONE_Q16)
    else $error("knee factor not saturated");

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SB = 24;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 1750;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB-1:0] out_sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [skde_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [skde_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  soft_knee_downward_expander_top #(.SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample_in(in_sample_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample_out(out_sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // expander state and register copies
  logic [63:0] peak_lvl, smooth_lvl;
  logic [15:0] peak_pole, attack_pole, release_pole;
  logic signed [15:0] knee_top;
  logic [17:0] knee_inv;
  logic signed [15:0] slope;

  logic signed [SB-1:0] sample_q[$];
  logic signed [SB-1:0] expected_q[$];
  int mismatches = 0;
  int watchdog = 0;
  bit hold_sender = 0;
  bit in_taken = 0;
  int burst_left = 0, gap_left = 0;
  int stall_phase = 0;

  function automatic logic [16:0] pow2_frac(input int i);
    case (i)
      0: return 17'd65536;   1: return 17'd62757;   2: return 17'd60097;
      3: return 17'd57549;   4: return 17'd55109;   5: return 17'd52773;
      6: return 17'd50535;   7: return 17'd48393;   8: return 17'd46341;
      9: return 17'd44376;   10: return 17'd42495;  11: return 17'd40693;
      12: return 17'd38968;  13: return 17'd37316;  14: return 17'd35734;
      15: return 17'd34219;  default: return 17'd32768;
    endcase
  endfunction

  function automatic longint level_db(input logic [63:0] lev);
    int pos;
    logic [63:0] m;
    logic [31:0] frac;
    longint l12;
    if (lev == 0) return -longint'(SB) * 1542;
    pos = 0;
    while (pos < 63 && (lev >> (pos + 1)) != 0) pos++;
    m = (pos >= 15) ? (lev >> (pos - 15)) : (lev << (15 - pos));
    frac = 0;
    for (int i = 0; i < 12; i++) begin
      m = (m * m) >> 15;
      frac = frac << 1;
      if (m >= 65536) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    l12 = (longint'(pos) - (SB - 1)) * 4096 + longint'(frac);
    if (l12 > 0) l12 = 0;
    return -longint'((64'(-l12) * 24660 + 32768) >> 16);
  endfunction

  function automatic logic signed [SB-1:0] expand_sample(input logic signed [SB-1:0] s);
    longint sv, d, a, b, r, g;
    logic [63:0] mag, x, coef, k, e, t, u, y, n;
    sv = s;
    mag = (sv < 0) ? 64'(-sv) : 64'(sv);
    peak_lvl = (peak_lvl * peak_pole + mag * (65536 - peak_pole) + 32768) >> 16;
    x = (sv > longint'(peak_lvl)) ? 64'(sv) : peak_lvl;
    coef = (smooth_lvl < x) ? attack_pole : release_pole;
    smooth_lvl = (smooth_lvl * coef + x * (65536 - coef) + 32768) >> 16;
    d = longint'(knee_top) - level_db(smooth_lvl);
    if (d < 0) d = 0;
    k = 64'(d) * knee_inv;
    if (k > 65536) k = 65536;
    e = (64'(d) * k + 32768) >> 16;
    t = (slope < 0) ? 64'(-longint'(slope)) * e : 0;
    u = (t * 54426 + (64'd1 << 20)) >> 21;
    n = u >> 16;
    if (n >= 17) g = 0;
    else begin
      a = pow2_frac(int'(u[15:12]));
      b = pow2_frac(int'(u[15:12]) + 1);
      r = u[11:0];
      g = (a - (((a - b) * r + 2048) >>> 12)) >>> n;
    end
    y = (mag * 64'(g) + 32768) >> 16;
    return (sv < 0) ? SB'(-y) : SB'(y);
  endfunction

  task automatic write_reg(input logic [skde_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skde_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      skde_pkg::REG_PEAK_DECAY: peak_pole = val[15:0];
      skde_pkg::REG_ATTACK:     attack_pole = val[15:0];
      skde_pkg::REG_RELEASE:    release_pole = val[15:0];
      skde_pkg::REG_KNEE_TOP:   knee_top = val[15:0];
      skde_pkg::REG_KNEE_RECIP: knee_inv = val;
      skde_pkg::REG_GAIN_SLOPE: slope = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (sample_q.size() == 0 && !in_valid && expected_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // realistic loud or quiet sample with random content
  function automatic logic signed [SB-1:0] rand_sample();
    int sel, sh;
    sel = $urandom_range(0, 9);
    if (sel < 2) return SB'($urandom);
    sh = $urandom_range(0, 23);
    return SB'($signed($urandom) >>> (8 + sh));
  endfunction

  task automatic queue_phase(input int count);
    for (int i = 0; i < count; i++) sample_q.push_back(rand_sample());
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_taken) begin
      end else if (!hold_sender && sample_q.size() > 0 && gap_left == 0) begin
        in_valid <= 1'b1;
        in_sample_in <= sample_q.pop_front();
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) out_ready <= 1'b1;
      else if (stall_phase % 512 < 256) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= (stall_phase % 37 > 15);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic signed [SB-1:0] want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_q.push_back(expand_sample(in_sample_in));
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) moved = 1'b1;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: sample_out=%0d", out_sample_out);
        end else begin
          want = expected_q.pop_front();
          if (want !== out_sample_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out mismatch: expected %0d, got %0d", want, out_sample_out);
          end
        end
      end
      watchdog <= moved ? 0 : watchdog + 1;
      if (watchdog >= WATCHDOG_LIMIT) begin
        $display("** soft_knee_downward_expander_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    peak_lvl = 0; smooth_lvl = 0;
    peak_pole = skde_pkg::RST_PEAK_DECAY;
    attack_pole = skde_pkg::RST_ATTACK;
    release_pole = skde_pkg::RST_RELEASE;
    knee_top = skde_pkg::RST_KNEE_TOP;
    knee_inv = skde_pkg::RST_KNEE_RECIP;
    slope = skde_pkg::RST_GAIN_SLOPE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero level, then loud level above the knee and a quiet run after it
    sample_q.push_back(24'sd0);
    sample_q.push_back(24'sd0);
    sample_q.push_back(24'sh7FFFFF);
    sample_q.push_back(-24'sd8388608);
    sample_q.push_back(24'sd1);
    sample_q.push_back(-24'sd1);
    sample_q.push_back(24'sh555555);
    sample_q.push_back(24'shAAAAAA);
    for (int i = 0; i < 6; i++) sample_q.push_back(24'sh7FFFFF);
    for (int i = 0; i < 6; i++) sample_q.push_back(24'sd3);
    wait_idle();

    // positive slope, huge knee factor, fast poles
    write_reg(skde_pkg::REG_GAIN_SLOPE, 18'h00123);
    write_reg(skde_pkg::REG_KNEE_RECIP, 18'h3FFFF);
    write_reg(skde_pkg::REG_PEAK_DECAY, 18'd0);
    write_reg(skde_pkg::REG_ATTACK, 18'd0);
    write_reg(skde_pkg::REG_RELEASE, 18'd0);
    queue_phase(250);
    wait_idle();

    // steepest slope and top knee: deep attenuation, gain to zero
    write_reg(skde_pkg::REG_GAIN_SLOPE, 18'(16'sh8000));
    write_reg(skde_pkg::REG_KNEE_TOP, 18'(16'sd7680));
    write_reg(skde_pkg::REG_PEAK_DECAY, 18'hFFFF);
    write_reg(skde_pkg::REG_ATTACK, 18'hFFFF);
    write_reg(skde_pkg::REG_RELEASE, 18'hFFFF);
    queue_phase(250);
    wait_idle();

    // lowest knee, zero recip, zero slope
    write_reg(skde_pkg::REG_KNEE_TOP, 18'(-16'sd24576));
    write_reg(skde_pkg::REG_KNEE_RECIP, 18'd0);
    write_reg(skde_pkg::REG_GAIN_SLOPE, 18'd0);
    queue_phase(200);
    wait_idle();

    // back toward defaults with random coefficients per phase
    for (int p = 0; p < 5; p++) begin
      write_reg(skde_pkg::REG_PEAK_DECAY, 18'($urandom_range(60000, 65535)));
      write_reg(skde_pkg::REG_ATTACK, 18'($urandom_range(0, 65535)));
      write_reg(skde_pkg::REG_RELEASE, 18'($urandom_range(50000, 65535)));
      write_reg(skde_pkg::REG_KNEE_TOP,
                18'(16'($signed($urandom_range(0, 32256)) - 24576)));
      write_reg(skde_pkg::REG_KNEE_RECIP, 18'($urandom_range(0, 2000)));
      write_reg(skde_pkg::REG_GAIN_SLOPE, 18'(16'(-$signed($urandom_range(0, 32768)))));
      queue_phase((N_RANDOM - 700) / 5);
      if (p == 2) begin
        // pause the sender until everything has drained
        wait (sample_q.size() < 100);
        hold_sender = 1;
        wait (!in_valid && expected_q.size() == 0);
        hold_sender = 0;
      end
      wait_idle();
    end

    if (mismatches == 0 && expected_q.size() == 0)
      $display("** soft_knee_downward_expander_top: PASSED **");
    else
      $display("** soft_knee_downward_expander_top: FAILED **");
    $finish;
  end
endmodule
